// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CAHP_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("cahp assertion failed");

// Next-cycle implication, disabled during reset.
`define CAHP_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("cahp assertion failed");

`endif

// ===== rtl/core/cahp_pkg.sv =====
`default_nettype none

package cahp_pkg;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_HEAD,
      PH_CHUNK,
      PH_SKIP,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_MAGIC     = 4'd1,
      ST_VERSION   = 4'd2,
      ST_FLAGS     = 4'd3,
      ST_NO_DESC   = 4'd4,
      ST_NOT_LPCM  = 4'd5,
      ST_BITS      = 4'd6,
      ST_INT32     = 4'd7,
      ST_TRUNCATED = 4'd8,
      ST_NEG_SIZE  = 4'd9
   } status_type;

   localparam logic [31:0] TAG_CAFF = 32'h6361_6666;
   localparam logic [31:0] TAG_DESC = 32'h6465_7363;
   localparam logic [31:0] TAG_LPCM = 32'h6c70_636d;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [5:0] OFS_MAGIC_END   = 6'd3;
   localparam logic [5:0] OFS_VERSION_END = 6'd5;
   localparam logic [5:0] OFS_FLAGS_END   = 6'd7;
   localparam logic [5:0] OFS_DESC_END    = 6'd11;
   localparam logic [5:0] OFS_RATE_END    = 6'd27;
   localparam logic [5:0] OFS_FORMAT_END  = 6'd31;
   localparam logic [5:0] OFS_FMTFLG_END  = 6'd35;
   localparam logic [5:0] OFS_CHAN_END    = 6'd47;
   localparam logic [5:0] OFS_BITS_END    = 6'd51;

   localparam logic [3:0] IDX_ID_END   = 4'd3;
   localparam logic [3:0] IDX_SIZE_END = 4'd11;

   localparam logic [63:0] DATA_HDR_BYTES = 64'd16;
   localparam logic [63:0] EDIT_COUNT_BYTES = 64'd4;

   typedef struct packed {
      logic [33:0] bytes_per_frame;
      logic [63:0] data_byte_limit;
      logic [62:0] header_bytes;
      logic        is_big_endian;
      logic [2:0]  bytes_per_sample;
      logic [31:0] channel_count;
      logic [63:0] sample_rate_bits;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/caf_audio_header_parser.sv =====
// Streaming header parser for CAF audio files. The file enters one byte per
// request, with tuser marking file offset zero and tlast marking the final
// byte; a byte is taken in every cycle in which the result register is free
// or being emptied, so the sustained rate is one byte per clock. Each byte is
// checked and folded into the parser state in the cycle it is taken, and the
// single result of a file (status plus the stream description) appears in
// the result register on the following cycle. Bytes that arrive before a
// first byte, or after the result of the current file, are consumed quietly.
`default_nettype none

module caf_audio_header_parser
   import cahp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tuser,   // [0] first_byte
   input  wire logic         req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [263:0]      rsp_tdata,   // [63:0] sample_rate_bits,
                                          // [95:64] channel_count,
                                          // [98:96] bytes_per_sample,
                                          // [99] is_big_endian,
                                          // [162:100] header_bytes,
                                          // [226:163] data_byte_limit,
                                          // [260:227] bytes_per_frame,
                                          // [263:261] zero
   output logic [3:0]        rsp_tuser    // [3:0] status
);

   phase_type   phase_ff, phase_in;
   logic [63:0] offset_ff, offset_in;
   logic [63:0] shift_ff, shift_in;
   logic [63:0] skip_ff, skip_in;
   logic [63:0] chunk_start_ff, chunk_start_in;
   logic [3:0]  chunk_idx_ff, chunk_idx_in;
   logic [1:0]  flags_ff, flags_in;
   logic [2:0]  bps_ff, bps_in;
   logic [31:0] channels_ff, channels_in;
   logic [63:0] rate_ff, rate_in;
   logic        is_data_ff, is_data_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   result_type  rsp_result_ff, rsp_result_in;

   logic        accept;
   logic        emit;
   status_type  status;
   logic [63:0] data_size;
   logic [63:0] next_offset;
   logic [63:0] skip_dec;
   logic [31:0] lo32;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      phase_in       = phase_ff;
      offset_in      = offset_ff;
      shift_in       = shift_ff;
      skip_in        = skip_ff;
      chunk_start_in = chunk_start_ff;
      chunk_idx_in   = chunk_idx_ff;
      flags_in       = flags_ff;
      bps_in         = bps_ff;
      channels_in    = channels_ff;
      rate_in        = rate_ff;
      is_data_in     = is_data_ff;
      emit           = 1'b0;
      status         = ST_OK;
      data_size      = '0;
      next_offset    = '0;
      skip_dec       = '0;
      lo32           = '0;

      if (accept && req_tuser) begin
         phase_in       = PH_HEAD;
         offset_in      = '0;
         shift_in       = '0;
         skip_in        = '0;
         chunk_start_in = '0;
         chunk_idx_in   = '0;
         flags_in       = '0;
         bps_in         = '0;
         channels_in    = '0;
         rate_in        = '0;
         is_data_in     = 1'b0;
      end

      if (accept && phase_in != PH_WAIT && phase_in != PH_DONE) begin
         shift_in    = {shift_in[55:0], req_tdata};
         lo32        = shift_in[31:0];
         next_offset = offset_in + 64'd1;
         skip_dec    = skip_in - 64'd1;

         unique case (phase_in)
            PH_HEAD: begin
               unique case (offset_in[5:0])
                  OFS_MAGIC_END: begin
                     if (lo32 != TAG_CAFF) begin
                        emit   = 1'b1;
                        status = ST_MAGIC;
                     end
                  end
                  OFS_VERSION_END: begin
                     if (lo32[15:0] != 16'd1) begin
                        emit   = 1'b1;
                        status = ST_VERSION;
                     end
                  end
                  OFS_FLAGS_END: begin
                     if (lo32[15:0] != 16'd0) begin
                        emit   = 1'b1;
                        status = ST_FLAGS;
                     end
                  end
                  OFS_DESC_END: begin
                     if (lo32 != TAG_DESC) begin
                        emit   = 1'b1;
                        status = ST_NO_DESC;
                     end
                  end
                  OFS_RATE_END: rate_in = shift_in;
                  OFS_FORMAT_END: begin
                     if (lo32 != TAG_LPCM) begin
                        emit   = 1'b1;
                        status = ST_NOT_LPCM;
                     end
                  end
                  OFS_FMTFLG_END: flags_in = lo32[1:0];
                  OFS_CHAN_END: channels_in = lo32;
                  OFS_BITS_END: begin
                     if (lo32 == 32'd16) begin
                        bps_in = 3'd2;
                     end else if (lo32 == 32'd24) begin
                        bps_in = 3'd3;
                     end else if (lo32 == 32'd32) begin
                        bps_in = 3'd4;
                     end
                     if (lo32 != 32'd16 && lo32 != 32'd24 && lo32 != 32'd32) begin
                        emit   = 1'b1;
                        status = ST_BITS;
                     end else if (lo32 == 32'd32 && !flags_in[0]) begin
                        emit   = 1'b1;
                        status = ST_INT32;
                     end else begin
                        chunk_start_in = next_offset;
                        chunk_idx_in   = '0;
                        phase_in       = PH_CHUNK;
                     end
                  end
                  default: ;
               endcase
            end
            PH_CHUNK: begin
               chunk_idx_in = chunk_idx_in + 4'd1;
               if (chunk_idx_ff == IDX_ID_END) begin
                  is_data_in = (lo32 == TAG_DATA);
               end
               if (chunk_idx_ff == IDX_SIZE_END) begin
                  priority if (is_data_ff) begin
                     emit      = 1'b1;
                     status    = ST_OK;
                     data_size = shift_in;
                  end else if (shift_in[63]) begin
                     emit   = 1'b1;
                     status = ST_NEG_SIZE;
                  end else if (shift_in == 64'd0) begin
                     chunk_start_in = next_offset;
                     chunk_idx_in   = '0;
                  end else begin
                     skip_in  = shift_in;
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 64'd0) begin
                  chunk_start_in = next_offset;
                  chunk_idx_in   = '0;
                  phase_in       = PH_CHUNK;
               end
            end
            default: ;
         endcase

         if (!emit && req_tlast) begin
            emit   = 1'b1;
            status = ST_TRUNCATED;
         end
         if (emit) begin
            phase_in = PH_DONE;
         end
         offset_in = next_offset;
      end
   end

   cahp_fields u_fields (
      .status      (status),
      .rate        (rate_in),
      .channels    (channels_in),
      .bps         (bps_in),
      .little_end  (flags_in[1]),
      .chunk_start (chunk_start_in),
      .data_size   (data_size),
      .result      (rsp_result_in)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         rsp_valid_ff <= 1'b0;
         chunk_idx_ff <= '0;
         is_data_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         chunk_idx_ff <= chunk_idx_in;
         is_data_ff   <= is_data_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff      <= offset_in;
      shift_ff       <= shift_in;
      skip_ff        <= skip_in;
      chunk_start_ff <= chunk_start_in;
      flags_ff       <= flags_in;
      bps_ff         <= bps_in;
      channels_ff    <= channels_in;
      rate_ff        <= rate_in;
      rsp_status_ff  <= rsp_status_in;
      if (emit) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_result_ff};

endmodule

`default_nettype wire

// ===== rtl/core/cahp_fields.sv =====
`default_nettype none

module cahp_fields
   import cahp_pkg::*;
(
   input  status_type  status,
   input  logic [63:0] rate,
   input  logic [31:0] channels,
   input  logic [2:0]  bps,
   input  logic        little_end,
   input  logic [63:0] chunk_start,
   input  logic [63:0] data_size,
   output result_type  result
);

   logic [33:0] frame_bytes;
   logic [63:0] hdr_sum;

   always_comb begin
      unique case (bps)
         3'd2:    frame_bytes = {1'b0, channels, 1'b0};
         3'd3:    frame_bytes = {1'b0, channels, 1'b0} + {2'b0, channels};
         3'd4:    frame_bytes = {channels, 2'b0};
         default: frame_bytes = '0;
      endcase
   end

   assign hdr_sum = chunk_start + DATA_HDR_BYTES;

   always_comb begin
      result = '0;
      if (status == ST_OK) begin
         result.sample_rate_bits = rate;
         result.channel_count    = channels;
         result.bytes_per_sample = bps;
         result.is_big_endian    = ~little_end;
         result.header_bytes     = hdr_sum[62:0];
         result.data_byte_limit  = data_size - EDIT_COUNT_BYTES;
         result.bytes_per_frame  = frame_bytes;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cahp_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module cahp_checker
   import cahp_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [263:0] rsp_tdata,
   input wire logic [3:0]   rsp_tuser
);

   logic         rsp_ok;
   logic         rsp_stuck;
   logic         rsp_error;
   logic         bps_legal;
   logic         frame_match;
   logic [267:0] rsp_word;
   logic [2:0]   rsp_bps;
   logic [33:0]  rsp_chans;

   assign rsp_ok      = rsp_tvalid && (rsp_tuser == ST_OK);
   assign rsp_stuck   = rsp_tvalid && !rsp_tready;
   assign rsp_error   = rsp_tvalid && (rsp_tuser != ST_OK);
   assign rsp_word    = {rsp_tuser, rsp_tdata};
   assign rsp_bps     = rsp_tdata[98:96];
   assign rsp_chans   = {2'b00, rsp_tdata[95:64]};
   assign bps_legal   = (rsp_bps == 3'd2) || (rsp_bps == 3'd3) || (rsp_bps == 3'd4);
   assign frame_match = rsp_tdata[260:227] == (rsp_chans * {31'd0, rsp_bps});

   `CAHP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stuck, rsp_tvalid && $stable(rsp_word))
   `CAHP_ASSERT_IMP(a_stall_only_when_full, clock, reset, !req_tready, rsp_tvalid)
   `CAHP_ASSERT_IMP(a_error_zero_fields, clock, reset, rsp_error, rsp_tdata == 264'd0)
   `CAHP_ASSERT_IMP(a_ok_sample_size, clock, reset, rsp_ok, bps_legal)
   `CAHP_ASSERT_IMP(a_ok_frame_size, clock, reset, rsp_ok, frame_match)

endmodule

bind caf_audio_header_parser cahp_checker u_checker (.*);

`default_nettype wire
